// ===== design/pidaw_pkg.sv =====
package pidaw_pkg;

  localparam int PidawDataWidth = 32;
  localparam int PidawFracBits  = 16;
  localparam int CfgIdxWidth    = 3;

  localparam logic [CfgIdxWidth-1:0] RegPropGain  = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegIntGain   = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegDerivGain = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegPeriod    = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegOutMin    = 3'd4;
  localparam logic [CfgIdxWidth-1:0] RegOutMax    = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN,
    ST_FIN,
    ST_DONE
  } pidaw_state_e;

  typedef enum logic [2:0] {
    OP_STEP,
    OP_ITERM,
    OP_DTERM,
    OP_DRIVE,
    OP_DONE
  } pidaw_op_e;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } pidaw_md_state_e;

  typedef struct packed {
    logic start;
    logic with_div;
  } pidaw_cmd_t;

endpackage

// ===== design/pidaw_muldiv.sv =====
module pidaw_muldiv
  import pidaw_pkg::*;
#(
  parameter int DATA_WIDTH = PidawDataWidth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pidaw_cmd_t                cmd_i,
  input  logic [DATA_WIDTH+1:0]     a_i,
  input  logic [DATA_WIDTH+1:0]     b_i,
  input  logic [DATA_WIDTH-2:0]     div_i,
  output logic                      done_o,
  output logic [2*DATA_WIDTH+3:0]   prod_o
);

  localparam int MW = DATA_WIDTH + 2;
  localparam int PW = 2 * MW;
  localparam int AW = MW + 1;
  localparam int CW = $clog2(PW);

  pidaw_md_state_e       phase_q, phase_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  with_div_q, with_div_d;
  logic                  done_q, done_d;
  logic [MW-1:0]         a_q, a_d;
  logic [DATA_WIDTH-2:0] d_q, d_d;
  logic [DATA_WIDTH-2:0] rem_q, rem_d;
  logic [PW-1:0]         prod_q, prod_d;

  logic [DATA_WIDTH-1:0] dv_t;
  logic [MW-1:0]         add_x, add_y;
  logic                  add_c;
  logic [AW-1:0]         add_s;
  logic [AW-1:0]         mul_hi;

  // shared adder: accumulate for shift-add, trial subtract for restoring divide
  always_comb begin
    dv_t = {rem_q, prod_q[PW-1]};
    if (phase_q == MD_DIV) begin
      add_x = MW'(dv_t);
      add_y = ~MW'(d_q);
      add_c = 1'b1;
    end else begin
      add_x = prod_q[PW-1:MW];
      add_y = a_q;
      add_c = 1'b0;
    end
    add_s  = {1'b0, add_x} + {1'b0, add_y} + AW'(add_c);
    mul_hi = prod_q[0] ? add_s : {1'b0, prod_q[PW-1:MW]};
  end

  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    with_div_d = with_div_q;
    done_d     = 1'b0;
    a_d        = a_q;
    d_d        = d_q;
    rem_d      = rem_q;
    prod_d     = prod_q;
    unique case (phase_q)
      MD_IDLE: begin
        if (cmd_i.start) begin
          a_d        = a_i;
          d_d        = div_i;
          with_div_d = cmd_i.with_div;
          prod_d     = {{MW{1'b0}}, b_i};
          rem_d      = '0;
          cnt_d      = CW'(MW - 1);
          phase_d    = MD_MUL;
        end
      end
      MD_MUL: begin
        prod_d = {mul_hi, prod_q[MW-1:1]};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          if (with_div_q) begin
            phase_d = MD_DIV;
            cnt_d   = CW'(PW - 1);
          end else begin
            phase_d = MD_IDLE;
            done_d  = 1'b1;
          end
        end
      end
      MD_DIV: begin
        rem_d  = add_s[MW] ? add_s[DATA_WIDTH-2:0] : dv_t[DATA_WIDTH-2:0];
        prod_d = {prod_q[PW-2:0], add_s[MW]};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          phase_d = MD_IDLE;
          done_d  = 1'b1;
        end
      end
      default: begin
        phase_d = MD_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= MD_IDLE;
      cnt_q      <= '0;
      with_div_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      with_div_q <= with_div_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    d_q    <= d_d;
    rem_q  <= rem_d;
    prod_q <= prod_d;
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

`ifndef NO_ASSERTIONS
  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |-> phase_q == MD_IDLE)
    else $error("muldiv started while busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("muldiv done held longer than one cycle");
`endif

endmodule

// ===== design/pid_regulator_antiwindup_top.sv =====
// Each input transfer runs its n (0..4) active products in sequence before the result is valid;
//   n counts the active products (integral step, integral term, derivative, drive);
//   the derivative adds a restoring divide by the period after its multiply.
// A new input is taken only once the previous result has been handed to the output register;
//   all products share one bit-serial shift-add/subtract unit.
// Reset: asynchronous, clears integral, previous error and output; registers take defaults.
module pid_regulator_antiwindup_top
  import pidaw_pkg::*;
#(
  parameter int DATA_WIDTH = PidawDataWidth,
  parameter int FRAC_BITS  = PidawFracBits
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [DATA_WIDTH-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [DATA_WIDTH-1:0]  measurement_i,
  input  logic [DATA_WIDTH-1:0]  setpoint_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [DATA_WIDTH-1:0]  drive_o
);

  localparam int W   = DATA_WIDTH;
  localparam int PdW = DATA_WIDTH - 1;
  localparam int MW  = DATA_WIDTH + 2;
  localparam int PW  = 2 * MW;

  localparam logic [W-1:0]  MaxVal  = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  MinVal  = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0]  UnitVal = W'(1) << FRAC_BITS;
  localparam logic [PW-1:0] MaskF   = (PW'(1) << FRAC_BITS) - PW'(1);
  localparam logic [PW-1:0] MaskF1  = (PW'(1) << (FRAC_BITS + 1)) - PW'(1);

  // configuration
  logic [W-1:0]   kp_q, ki_q, kd_q, omin_q, omax_q;
  logic [PdW-1:0] period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q     <= UnitVal;
      ki_q     <= '0;
      kd_q     <= '0;
      period_q <= UnitVal[PdW-1:0];
      omin_q   <= MinVal;
      omax_q   <= MaxVal;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegPropGain:  kp_q     <= cfg_data_i;
        RegIntGain:   ki_q     <= cfg_data_i;
        RegDerivGain: kd_q     <= cfg_data_i;
        RegPeriod:    period_q <= cfg_data_i[PdW-1:0];
        RegOutMin:    omin_q   <= cfg_data_i;
        RegOutMax:    omax_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer state
  pidaw_state_e state_q, state_d;
  pidaw_op_e    op_q, op_d;
  logic         neg_q, neg_d;
  logic [W:0]   err_q, err_d, prev_err_q, prev_err_d;
  logic [W-1:0] integ_q, integ_d, prev_out_q, prev_out_d;
  logic [W-1:0] iterm_q, iterm_d, dterm_q, dterm_d, drive_q, drive_d;
  logic         out_valid_q, out_valid_d;
  logic [W-1:0] out_drive_q, out_drive_d;

  logic [PdW-1:0] period_eff;
  logic [MW-1:0]  esum, ediff, sa, sb, a_mag, b_mag;
  logic [W-1:0]   p_term, pid_sat;
  logic [W+1:0]   pid_sum;
  logic           en_step, en_iterm, en_dterm, en_drive;
  pidaw_op_e      from_step, from_iterm, from_dterm, from_drive, op_next;
  logic [PW-1:0]  prod, q;
  logic           rbit, big;
  logic [W-1:0]   ql, res, integ_sat, clamped;
  logic [W:0]     integ_sum;
  logic           md_done;
  pidaw_cmd_t     md_cmd;

  assign period_eff = (period_q == '0) ? PdW'(1) : period_q;
  assign esum  = {err_q[W], err_q} + {prev_err_q[W], prev_err_q};
  assign ediff = {err_q[W], err_q} - {prev_err_q[W], prev_err_q};

  assign p_term = (err_q[W] != err_q[W-1]) ? (err_q[W] ? MinVal : MaxVal) : err_q[W-1:0];
  assign pid_sum = {{2{p_term[W-1]}}, p_term} + {{2{iterm_q[W-1]}}, iterm_q}
                 + {{2{dterm_q[W-1]}}, dterm_q};
  assign pid_sat = (pid_sum[W+1:W-1] == 3'b000 || pid_sum[W+1:W-1] == 3'b111)
                 ? pid_sum[W-1:0] : (pid_sum[W+1] ? MinVal : MaxVal);

  // anti-windup: integrate only while last drive sat strictly inside the limits
  assign en_iterm = (ki_q != '0);
  assign en_step  = en_iterm && ($signed(omin_q) < $signed(prev_out_q))
                  && ($signed(prev_out_q) < $signed(omax_q));
  assign en_dterm = (kd_q != '0);
  assign en_drive = (kp_q != '0);

  assign from_drive = en_drive ? OP_DRIVE : OP_DONE;
  assign from_dterm = en_dterm ? OP_DTERM : from_drive;
  assign from_iterm = en_iterm ? OP_ITERM : from_dterm;
  assign from_step  = en_step  ? OP_STEP  : from_iterm;

  always_comb begin
    case (op_q)
      OP_STEP:  op_next = from_iterm;
      OP_ITERM: op_next = from_dterm;
      OP_DTERM: op_next = from_drive;
      default:  op_next = OP_DONE;
    endcase
  end

  // operand selection, signed then magnitude
  always_comb begin
    sa = '0;
    sb = '0;
    case (op_q)
      OP_STEP: begin
        sa = MW'(period_eff);
        sb = esum;
      end
      OP_ITERM: begin
        sa = {{2{ki_q[W-1]}}, ki_q};
        sb = {{2{integ_q[W-1]}}, integ_q};
      end
      OP_DTERM: begin
        sa = {{2{kd_q[W-1]}}, kd_q};
        sb = ediff;
      end
      OP_DRIVE: begin
        sa = {{2{kp_q[W-1]}}, kp_q};
        sb = {{2{pid_sat[W-1]}}, pid_sat};
      end
      default: ;
    endcase
    a_mag = sa[MW-1] ? -sa : sa;
    b_mag = sb[MW-1] ? -sb : sb;
  end

  // scale (not the derivative quotient), floor rounding for negative scaled results, saturate
  always_comb begin
    q    = prod;
    rbit = 1'b0;
    case (op_q) inside
      OP_STEP: begin
        q    = prod >> (FRAC_BITS + 1);
        rbit = |(prod & MaskF1);
      end
      OP_ITERM, OP_DRIVE: begin
        q    = prod >> FRAC_BITS;
        rbit = |(prod & MaskF);
      end
      default: ;
    endcase
    big = |q[PW-1:W];
    ql  = q[W-1:0];
    if (!neg_q) begin
      res = (big || ql[W-1]) ? MaxVal : ql;
    end else if (rbit) begin
      res = (big || ql[W-1]) ? MinVal : ~ql;
    end else begin
      res = (big || (ql[W-1] && (|ql[W-2:0]))) ? MinVal : -ql;
    end
    integ_sum = {integ_q[W-1], integ_q} + {res[W-1], res};
    integ_sat = (integ_sum[W] != integ_sum[W-1])
              ? (integ_sum[W] ? MinVal : MaxVal) : integ_sum[W-1:0];
  end

  always_comb begin
    if ($signed(drive_q) > $signed(omax_q)) begin
      clamped = omax_q;
    end else if ($signed(drive_q) < $signed(omin_q)) begin
      clamped = omin_q;
    end else begin
      clamped = drive_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    neg_d       = neg_q;
    err_d       = err_q;
    prev_err_d  = prev_err_q;
    integ_d     = integ_q;
    prev_out_d  = prev_out_q;
    iterm_d     = iterm_q;
    dterm_d     = dterm_q;
    drive_d     = drive_q;
    out_drive_d = out_drive_q;
    out_valid_d = out_valid_q && !out_ready_i;
    md_cmd      = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          err_d   = {setpoint_i[W-1], setpoint_i} - {measurement_i[W-1], measurement_i};
          iterm_d = '0;
          dterm_d = '0;
          drive_d = prev_out_q;
          op_d    = from_step;
          state_d = (from_step == OP_DONE) ? ST_DONE : ST_SETUP;
        end
      end
      ST_SETUP: begin
        md_cmd.start    = 1'b1;
        md_cmd.with_div = (op_q == OP_DTERM);
        neg_d           = sa[MW-1] ^ sb[MW-1];
        state_d         = ST_RUN;
      end
      ST_RUN: begin
        if (md_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        case (op_q)
          OP_STEP:  integ_d = integ_sat;
          OP_ITERM: iterm_d = res;
          OP_DTERM: dterm_d = res;
          OP_DRIVE: drive_d = res;
          default: ;
        endcase
        op_d    = op_next;
        state_d = (op_next == OP_DONE) ? ST_DONE : ST_SETUP;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_drive_d = clamped;
          out_valid_d = 1'b1;
          prev_out_d  = clamped;
          prev_err_d  = err_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_DONE;
      neg_q       <= 1'b0;
      err_q       <= '0;
      prev_err_q  <= '0;
      integ_q     <= '0;
      prev_out_q  <= '0;
      iterm_q     <= '0;
      dterm_q     <= '0;
      drive_q     <= '0;
      out_valid_q <= 1'b0;
      out_drive_q <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      neg_q       <= neg_d;
      err_q       <= err_d;
      prev_err_q  <= prev_err_d;
      integ_q     <= integ_d;
      prev_out_q  <= prev_out_d;
      iterm_q     <= iterm_d;
      dterm_q     <= dterm_d;
      drive_q     <= drive_d;
      out_valid_q <= out_valid_d;
      out_drive_q <= out_drive_d;
    end
  end

  pidaw_muldiv #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (md_cmd),
    .a_i    (a_mag),
    .b_i    (b_mag),
    .div_i  (period_eff),
    .done_o (md_done),
    .prod_o (prod)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign drive_o     = out_drive_q;

`ifndef NO_ASSERTIONS
  a_setup_has_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SETUP |-> op_q != OP_DONE)
    else $error("product setup without a pending operation");

  a_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_done |-> state_q == ST_RUN)
    else $error("muldiv completion outside run state");

  a_drive_in_limits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && (!out_valid_q || out_ready_i)
      && $signed(omin_q) <= $signed(omax_q))
    |=> ($signed(drive_o) >= $signed($past(omin_q))
      && $signed(drive_o) <= $signed($past(omax_q))))
    else $error("drive outside configured limits");
`endif

endmodule
